>>> sv/edf_pkg.sv
package edf_pkg;

  // task slots in the register map and tasks that actually take part
  localparam int TASK_SLOTS  = 8;
  localparam int NUM_TASKS   = 8;
  localparam int TASK_IDX_W  = 3;
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 64;

  localparam int TIME_W   = 32;
  localparam int BUDGET_W = 16;
  localparam int SPAN_W   = 24;

  // flips the sign bit so a signed distance orders as unsigned
  localparam logic [TIME_W-1:0] KEY_FLIP = {1'b1, {(TIME_W-1){1'b0}}};

  // packed register layout: deadline 63:40, period 39:16, execution time 15:0
  typedef struct packed {
    logic [SPAN_W-1:0]   rel_deadline;
    logic [SPAN_W-1:0]   period;
    logic [BUDGET_W-1:0] exec_time;
  } task_cfg_t;

  typedef struct packed {
    logic fire;
    logic restart;
    logic run;
  } task_ctl_t;

  typedef struct packed {
    logic              eligible;
    logic [TIME_W-1:0] key;
  } task_status_t;

  typedef struct packed {
    logic                  found;
    logic [TASK_IDX_W-1:0] idx;
  } pick_t;

endpackage

>>> sv/edf_task.sv
module edf_task (
  input  logic                        clk,
  input  logic                        rst,
  input  edf_pkg::task_cfg_t          cfg,
  input  edf_pkg::task_ctl_t          ctl,
  input  logic [edf_pkg::TIME_W-1:0]  now_eff,
  output edf_pkg::task_status_t       status
);
  import edf_pkg::*;

  logic [BUDGET_W-1:0] budget;
  logic [TIME_W-1:0]   next_release;
  logic [TIME_W-1:0]   abs_deadline;

  logic [BUDGET_W-1:0] cur_budget;
  logic [TIME_W-1:0]   cur_release;
  logic [TIME_W-1:0]   cur_deadline;
  logic                enabled;
  logic                release_now;
  logic [BUDGET_W-1:0] budget_rel;

  logic [BUDGET_W-1:0] budget_next;
  logic [TIME_W-1:0]   next_release_next;
  logic [TIME_W-1:0]   abs_deadline_next;

  always_comb begin
    cur_budget   = ctl.restart ? '0 : budget;
    cur_release  = ctl.restart ? '0 : next_release;
    cur_deadline = ctl.restart ? '0 : abs_deadline;

    enabled     = (cfg.exec_time != '0) && (cfg.period != '0);
    release_now = enabled && (cur_release == now_eff);
    budget_rel  = release_now ? cfg.exec_time : cur_budget;

    status.eligible = enabled && (budget_rel != '0);
    // a fresh release is exactly rel_deadline ahead of now
    if (release_now) begin
      status.key = {1'b1, {(TIME_W-SPAN_W-1){1'b0}}, cfg.rel_deadline};
    end else begin
      status.key = (cur_deadline - now_eff) ^ KEY_FLIP;
    end

    budget_next       = ctl.run ? (budget_rel - BUDGET_W'(1)) : budget_rel;
    next_release_next = release_now ? (now_eff + TIME_W'(cfg.period)) : cur_release;
    abs_deadline_next = release_now ? (now_eff + TIME_W'(cfg.rel_deadline)) : cur_deadline;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      budget       <= '0;
      next_release <= '0;
      abs_deadline <= '0;
    end else if (ctl.fire) begin
      budget       <= budget_next;
      next_release <= next_release_next;
      abs_deadline <= abs_deadline_next;
    end
  end

endmodule

>>> sv/edf_arbiter.sv
module edf_arbiter (
  input  edf_pkg::task_status_t status [edf_pkg::TASK_SLOTS],
  output edf_pkg::pick_t        pick
);
  import edf_pkg::*;

  localparam int NODES = 2 * TASK_SLOTS;

  typedef struct packed {
    logic                  found;
    logic [TIME_W-1:0]     key;
    logic [TASK_IDX_W-1:0] idx;
  } node_t;

  node_t node [1:NODES-1];

  // left side holds the lower indexes and wins a tie
  function automatic node_t merge(input node_t a, input node_t b);
    node_t r;
    if (a.found && (!b.found || a.key <= b.key)) begin
      r = a;
    end else begin
      r = b;
    end
    return r;
  endfunction

  always_comb begin
    for (int i = 0; i < TASK_SLOTS; i++) begin
      node[TASK_SLOTS + i].found = status[i].eligible;
      node[TASK_SLOTS + i].key   = status[i].key;
      node[TASK_SLOTS + i].idx   = TASK_IDX_W'(i);
    end
    for (int n = TASK_SLOTS - 1; n >= 1; n--) begin
      node[n] = merge(node[2*n], node[2*n+1]);
    end
    pick.found = node[1].found;
    pick.idx   = node[1].idx;
  end

endmodule

>>> sv/edf_tick_scheduler.sv
// channel  direction  transaction                      signals
// -------  ---------  -------------------------------  --------------------------------------
// in       sink       one timer tick                   in_valid, in_ready, restart
// out      source     one scheduling decision          out_valid, out_ready, busy_res,
//                                                      task_index, tick_time
// cfg      sink       write of one task register       cfg_valid, cfg_ready, cfg_index, cfg_data
//
// one tick per cycle sustained while the output is not stalled; a tick is evaluated while it
// sits in the input register, and its decision is registered onto the out port when it fires.
// the rate is set by the per-tick state update (release, compare tree, budget decrement),
// which is combinational.
// rst is synchronous: it clears task state, time, register map and both stages.
// a stalled output only holds the input register; cfg writes are always taken.
module edf_tick_scheduler (
  input  logic                                clk,
  input  logic                                rst,

  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                restart,

  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                busy_res,
  output logic [edf_pkg::TASK_IDX_W-1:0]      task_index,
  output logic [edf_pkg::TIME_W-1:0]          tick_time,

  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [edf_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [edf_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import edf_pkg::*;

  // register map, one packed word per task slot
  task_cfg_t    task_cfg [TASK_SLOTS];

  // input register
  logic         s1_valid;
  logic         s1_restart;

  // tick counter
  logic [TIME_W-1:0] now;
  logic [TIME_W-1:0] now_eff;

  logic         fire;
  task_ctl_t    ctl [NUM_TASKS];
  task_status_t status_all [TASK_SLOTS];
  pick_t        pick;

  // config writes: beyond the last slot they are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TASK_SLOTS; i++) begin
        task_cfg[i] <= '0;
      end
    end else if (cfg_valid && cfg_ready && (cfg_index < CFG_INDEX_W'(TASK_SLOTS))) begin
      task_cfg[cfg_index[TASK_IDX_W-1:0]] <= task_cfg_t'(cfg_data);
    end
  end

  // evaluate whenever the output register is free or being drained
  assign fire     = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_restart <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_restart <= restart;
    end
  end

  // restart clears time before this tick is looked at
  assign now_eff = s1_restart ? '0 : now;

  always_ff @(posedge clk) begin
    if (rst) begin
      now <= '0;
    end else if (fire) begin
      now <= now_eff + TIME_W'(1);
    end
  end

  // per-task release, urgency key and budget state
  for (genvar g = 0; g < NUM_TASKS; g++) begin : g_task
    always_comb begin
      ctl[g].fire    = fire;
      ctl[g].restart = s1_restart;
      ctl[g].run     = fire && pick.found && (pick.idx == TASK_IDX_W'(g));
    end

    edf_task u_task (
      .clk     (clk),
      .rst     (rst),
      .cfg     (task_cfg[g]),
      .ctl     (ctl[g]),
      .now_eff (now_eff),
      .status  (status_all[g])
    );
  end

  // unused slots never compete
  for (genvar g = NUM_TASKS; g < TASK_SLOTS; g++) begin : g_pad
    assign status_all[g] = '0;
  end

  // earliest deadline, lowest index on a tie
  edf_arbiter u_arbiter (
    .status (status_all),
    .pick   (pick)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      busy_res   <= pick.found;
      task_index <= pick.found ? pick.idx : '0;
      tick_time  <= now_eff;
    end
  end

`ifndef SYNTHESIS
  // the arbiter only names a task that has work left
  a_pick_eligible: assert property (@(posedge clk) disable iff (rst)
    pick.found |-> status_all[pick.idx].eligible)
    else $error("picked task has no work left");

  // time steps by one per evaluated tick
  a_time_step: assert property (@(posedge clk) disable iff (rst)
    fire |=> now == $past(now_eff) + TIME_W'(1))
    else $error("tick counter out of step");

  // an idle decision reports slot zero
  a_idle_index: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !busy_res) |-> task_index == '0)
    else $error("idle tick with nonzero task index");

  // input side only stalls behind a full, blocked result register
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (s1_valid && out_valid && !out_ready))
    else $error("input stalled without a blocked result");
`endif

endmodule

>>> test/edf_tick_scheduler_tb.sv
module edf_tick_scheduler_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import edf_pkg::*;

  // one scheduling decision as seen on the out channel
  typedef struct packed {
    logic                  busy;
    logic [TASK_IDX_W-1:0] idx;
    logic [TIME_W-1:0]     tick;
  } decision_t;

  // families of task sets loaded into the register map between phases
  typedef enum int {MIX_DIRECTED, MIX_EXTREME, MIX_TIGHT, MIX_WILD, MIX_SPARSE} task_mix_t;

  localparam int STALL_LIMIT   = 5000;
  localparam int PHASE_TICKS   = 320;
  localparam int NUM_PHASES    = 6;
  localparam int SETTLE_CYCLES = 4;

  // packed as {rel_deadline, period, exec_time}
  localparam logic [CFG_DATA_W-1:0] DIRECTED_SET [TASK_SLOTS] = '{
    {24'd3, 24'd4, 16'd2},           // equal to task 1, lower index wins the tie
    {24'd3, 24'd4, 16'd2},
    {24'd1, 24'd2, 16'd3},           // released again before its job is done
    {24'd5, 24'd0, 16'd1},           // no period, never runs
    {24'd2, 24'd6, 16'd0},           // no execution time, never runs
    {24'd9, 24'd9, 16'd1},
    {24'd0, 24'd0, 16'd0},
    {24'd0, 24'd0, 16'd0}
  };

  localparam logic [CFG_DATA_W-1:0] EXTREME_SET [TASK_SLOTS] = '{
    {24'hFFFFFF, 24'hFFFFFF, 16'hFFFF},
    {24'h000000, 24'h000001, 16'h0001},  // due at its own release, every tick
    {24'h000000, 24'h000001, 16'hFFFF},  // budget overwritten every tick
    {24'hFFFFFF, 24'hFFFFFF, 16'h0000},
    {24'h000000, 24'h000000, 16'hFFFF},
    {24'h000001, 24'h000003, 16'h0002},
    {24'h800000, 24'h000002, 16'h0001},
    {24'h000000, 24'hFFFFFF, 16'h0001}   // overdue after one tick, beats everything
  };

  localparam task_mix_t PHASE_MIX [NUM_PHASES] = '{
    MIX_TIGHT, MIX_WILD, MIX_SPARSE, MIX_TIGHT, MIX_EXTREME, MIX_SPARSE
  };
  // the second tight phase keeps the old timing so new values apply at next release
  localparam bit PHASE_RESTART [NUM_PHASES] = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};

  // scoreboard: tracks the scheduler timing state and queues expected decisions
  class edf_scoreboard_t;
    task_cfg_t           regs       [TASK_SLOTS];
    logic [TIME_W-1:0]   cur_time;
    logic [BUDGET_W-1:0] units_left [TASK_SLOTS];
    logic [TIME_W-1:0]   release_at [TASK_SLOTS];
    logic [TIME_W-1:0]   due_at     [TASK_SLOTS];
    decision_t           decisions_q [$];
    int                  mismatches;
    int                  decided;
    int                  busy_ticks;
    int                  restarts;
    int                  writes;

    function new();
      foreach (regs[i]) regs[i] = '0;
      clear_timing();
      mismatches = 0;
      decided    = 0;
      busy_ticks = 0;
      restarts   = 0;
      writes     = 0;
    endfunction

    function void clear_timing();
      cur_time = '0;
      foreach (units_left[i]) begin
        units_left[i] = '0;
        release_at[i] = '0;
        due_at[i]     = '0;
      end
    endfunction

    function bit enabled(int i);
      return (regs[i].exec_time != '0) && (regs[i].period != '0);
    endfunction

    function void note_write(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      writes++;
      if (idx < CFG_INDEX_W'(TASK_SLOTS)) regs[idx[TASK_IDX_W-1:0]] = task_cfg_t'(data);
    endfunction

    function void note_tick(logic rs);
      decision_t         d;
      logic [TIME_W-1:0] key;
      logic [TIME_W-1:0] best_key;
      bit                found;
      int                pick;
      int                i;
      found    = 1'b0;
      pick     = 0;
      best_key = '0;
      if (rs) begin
        clear_timing();
        restarts++;
      end
      // releases first
      for (i = 0; i < NUM_TASKS; i++) begin
        if (enabled(i) && release_at[i] == cur_time) begin
          units_left[i] = regs[i].exec_time;
          release_at[i] = cur_time + TIME_W'(regs[i].period);
          due_at[i]     = cur_time + TIME_W'(regs[i].rel_deadline);
        end
      end
      // earliest deadline by signed distance from now, lowest index on a tie
      for (i = 0; i < NUM_TASKS; i++) begin
        if (enabled(i) && units_left[i] != '0) begin
          key = (due_at[i] - cur_time) ^ KEY_FLIP;
          if (!found || key < best_key) begin
            found    = 1'b1;
            pick     = i;
            best_key = key;
          end
        end
      end
      if (found) begin
        units_left[pick] = units_left[pick] - 1'b1;
        busy_ticks++;
      end
      d.busy = found;
      d.idx  = found ? TASK_IDX_W'(pick) : '0;
      d.tick = cur_time;
      decisions_q.push_back(d);
      cur_time = cur_time + 1'b1;
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      $display("mismatch: %s", msg);
    endtask

    task check_decision(logic busy, logic [TASK_IDX_W-1:0] idx, logic [TIME_W-1:0] tick);
      decision_t want;
      if (decisions_q.size() == 0) begin
        report_mismatch($sformatf("decision for tick %0d with no tick pending", tick));
      end else begin
        want = decisions_q.pop_front();
        decided++;
        if (busy !== want.busy)
          report_mismatch($sformatf("tick %0d: busy_res %b, want %b", want.tick, busy,
                                    want.busy));
        if (idx !== want.idx)
          report_mismatch($sformatf("tick %0d: task_index %0d, want %0d", want.tick, idx,
                                    want.idx));
        if (tick !== want.tick)
          report_mismatch($sformatf("tick_time %0d, want %0d", tick, want.tick));
      end
    endtask
  endclass

  logic                   clk        = 1'b0;
  logic                   rst        = 1'b1;
  logic                   in_valid   = 1'b0;
  logic                   in_ready;
  logic                   restart    = 1'b0;
  logic                   out_valid;
  logic                   out_ready  = 1'b0;
  logic                   busy_res;
  logic [TASK_IDX_W-1:0]  task_index;
  logic [TIME_W-1:0]      tick_time;
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index  = '0;
  logic [CFG_DATA_W-1:0]  cfg_data   = '0;

  int              send_idle_pct = 10;
  int              recv_idle_pct = 71;
  int              stall_cycles  = 0;
  edf_scoreboard_t sb;

  edf_tick_scheduler uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .restart    (restart),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .busy_res   (busy_res),
    .task_index (task_index),
    .tick_time  (tick_time),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // receiver backpressure, redrawn every cycle
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // monitor: every transaction is sampled with its pre-edge values
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.note_write(cfg_index, cfg_data);
      if (in_valid && in_ready) sb.note_tick(restart);
      if (out_valid && out_ready) sb.check_decision(busy_res, task_index, tick_time);
    end
  end

  // watchdog: too long without any transaction means a hang
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("edf_tick_scheduler_tb NOT OK");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // one tick transaction, with a random gap before it; valid stays up when there is none
  task automatic send_tick(logic rs);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    restart  <= rs;
    do @(posedge clk); while (!in_ready);
  endtask

  // hold off the sender until every pending decision has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.decisions_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(int idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_INDEX_W'(idx);
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // load all task registers, plus one write to an unmapped index that must be dropped
  task automatic program_tasks(task_mix_t mix);
    task_cfg_t c;
    int        i;
    for (i = 0; i < TASK_SLOTS; i++) begin
      case (mix)
        MIX_DIRECTED: begin
          c = DIRECTED_SET[i];
        end
        MIX_EXTREME: begin
          c = EXTREME_SET[i];
        end
        MIX_TIGHT: begin
          c.exec_time    = ($urandom_range(7) == 0) ? '0 : BUDGET_W'($urandom_range(4, 1));
          c.period       = SPAN_W'($urandom_range(12, 2));
          c.rel_deadline = SPAN_W'($urandom_range(14));
        end
        MIX_SPARSE: begin
          c.exec_time    = BUDGET_W'($urandom_range(3, 1));
          c.period       = SPAN_W'($urandom_range(60, 20));
          c.rel_deadline = SPAN_W'($urandom_range(80));
        end
        default: begin
          // any bit pattern at all
          c = {$urandom, $urandom};
        end
      endcase
      write_reg(i, c);
    end
    write_reg($urandom_range((1 << CFG_INDEX_W) - 1, TASK_SLOTS), {$urandom, $urandom});
    cfg_valid <= 1'b0;
  endtask

  initial begin
    bit rs;
    int p;
    int n;
    sb = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: ties, overwritten budgets, disabled tasks, a mid-run restart
    program_tasks(MIX_DIRECTED);
    for (n = 0; n < 14; n++) send_tick(1'b0);
    send_tick(1'b1);
    for (n = 0; n < 3; n++) send_tick(1'b0);
    wait_drained();

    // field extremes and overdue deadlines
    program_tasks(MIX_EXTREME);
    send_tick(1'b1);
    for (n = 0; n < 5; n++) send_tick(1'b0);

    // random phases: slow receiver, then slow sender, then full rate
    for (p = 0; p < NUM_PHASES; p++) begin
      wait_drained();
      if (p < 2) begin
        send_idle_pct = 10;
        recv_idle_pct = 71;
      end else if (p < 4) begin
        send_idle_pct = 71;
        recv_idle_pct = 10;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      program_tasks(PHASE_MIX[p]);
      for (n = 0; n < PHASE_TICKS; n++) begin
        rs = (n == 0 && PHASE_RESTART[p]) || ($urandom_range(49) == 0);
        send_tick(rs);
        // let the pipeline empty completely once per phase
        if (n == PHASE_TICKS / 2) wait_drained();
      end
    end
    wait_drained();

    $display("checked %0d tick decisions (%0d busy, %0d restarts) over %0d register writes",
             sb.decided, sb.busy_ticks, sb.restarts, sb.writes);
    $display("task sets: directed, extreme, tight, random 64-bit, sparse; %0d mismatches",
             sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("edf_tick_scheduler_tb OK");
    end else begin
      $display("edf_tick_scheduler_tb NOT OK");
    end
    $finish;
  end

endmodule
